// File: hw/rtl/bblp_pkg.sv
// ----------------------------------------------------------------------------
// bblp_pkg: shared types for the box blur line pass
// Pixel, job and result beat formats plus fixed widths.
// ----------------------------------------------------------------------------
package bblp_pkg;

  localparam int unsigned MaxRadiusDef = 63;
  localparam int unsigned MaxLineDef   = 4096;
  localparam int unsigned SumW         = 15;  // window sum at the largest radius
  localparam int unsigned CntW         = 7;   // window count at the largest radius
  localparam int unsigned PosW         = 12;
  localparam int unsigned JobDepth     = 4;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic [7:0] pixel_alpha;
    logic       line_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0]      blur_blue;
    logic [7:0]      blur_green;
    logic [7:0]      blur_red;
    logic [7:0]      blur_alpha;
    logic [PosW-1:0] out_position;
    logic            out_line_end;
  } result_t;

  // one window ready for division: channel sums in B,G,R,A order
  typedef struct packed {
    logic [3:0][SumW-1:0] sums;
    logic [CntW-1:0]      count;
    logic [PosW-1:0]      pos;
    logic                 last;
  } job_t;

endpackage

// File: hw/rtl/bblp_fifo.sv
// ----------------------------------------------------------------------------
// bblp_fifo: job queue
// Short register queue between the window front end and the divider.
// ----------------------------------------------------------------------------
module bblp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bblp_pkg::job_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bblp_pkg::job_t out_o
);

  localparam int unsigned D  = bblp_pkg::JobDepth;
  localparam int unsigned AW = $clog2(D);

  bblp_pkg::job_t  mem_q [D];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            wr_en, rd_en;

  assign in_ready_o  = cnt_q != (AW+1)'(D);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];
  assign wr_en       = in_valid_i && in_ready_o;
  assign rd_en       = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == AW'(D-1)) ? '0 : wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= (rd_q == AW'(D-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

// File: hw/rtl/bblp_front.sv
// ----------------------------------------------------------------------------
// bblp_front: window front end
// Keeps the pixel window and running sums, issues one job per output pixel.
// ----------------------------------------------------------------------------
module bblp_front #(
  parameter int unsigned MAX_RADIUS = bblp_pkg::MaxRadiusDef,
  parameter int unsigned MAX_LINE   = bblp_pkg::MaxLineDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  output logic               pix_ready_o,
  input  bblp_pkg::pixel_t   pix_i,
  input  logic [5:0]         radius_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output bblp_pkg::job_t     job_o
);

  localparam int unsigned D  = 2*MAX_RADIUS + 1;
  localparam int unsigned AW = $clog2(D);
  localparam int unsigned CW = $clog2(D + 1);
  localparam int unsigned SW = 8 + CW;
  localparam int unsigned PW = $clog2(MAX_LINE);
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned XW = ((PW > RW) ? PW : RW) + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_DCHK  = 3'd3;
  localparam logic [2:0] S_DSUB  = 3'd4;
  localparam logic [2:0] S_DEMIT = 3'd5;

  logic [31:0]         mem_q [D];
  logic [31:0]         rd_q;
  logic [2:0]          state_q, state_d;
  logic [PW-1:0]       pos_q, pos_d, lo_q, lo_d, x_q, x_d;
  logic [RW-1:0]       r_q, r_d, r_sat;
  logic [31:0]         px_q;
  logic                last_q, last_d, drop_q, drop_d;
  logic [AW-1:0]       wp_q, wp_d, tail_q, tail_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [3:0][SW-1:0]  sum_q, sum_d;
  logic                accept, emit_ok;
  logic [PW-1:0]       emit_pos;
  logic [31:0]         px_in;

  assign accept  = pix_valid_i && pix_ready_o;
  assign px_in   = {pix_i.pixel_alpha, pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue};
  assign r_sat   = (XW'(radius_i) > XW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_i);
  assign emit_ok = XW'(pos_q) >= XW'(r_q);
  assign emit_pos = PW'(XW'(pos_q) - XW'(r_q));

  assign pix_ready_o = state_q == S_IDLE;
  assign job_valid_o = (state_q == S_DEMIT) || (state_q == S_EMIT && !last_q && emit_ok);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      job_o.sums[c] = bblp_pkg::SumW'(sum_q[c]);
    end
    job_o.count = bblp_pkg::CntW'(cnt_q);
    job_o.pos   = bblp_pkg::PosW'((state_q == S_DEMIT) ? x_q : emit_pos);
    job_o.last  = (state_q == S_DEMIT) && (x_q == pos_q);
  end

  // window store: write on accept, oldest entry read every cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wp_q] <= px_in;
    end
    rd_q <= mem_q[tail_q];
    if (accept) begin
      px_q <= px_in;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    lo_d    = lo_q;
    x_d     = x_q;
    r_d     = r_q;
    last_d  = last_q;
    drop_d  = drop_q;
    wp_d    = wp_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          r_d     = (pos_q == '0) ? r_sat : r_q;
          drop_d  = XW'(pos_q) >= ((XW'(r_d) << 1) + XW'(1));
          last_d  = pix_i.line_end || (pos_q == PW'(MAX_LINE - 1));
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int c = 0; c < 4; c++) begin
          sum_d[c] = sum_q[c] + SW'(px_q[8*c +: 8]) - (drop_q ? SW'(rd_q[8*c +: 8]) : SW'(0));
        end
        cnt_d = cnt_q + CW'(1) - CW'(drop_q);
        if (drop_q) begin
          tail_d = (tail_q == AW'(D-1)) ? '0 : tail_q + 1'b1;
          lo_d   = lo_q + 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (last_q) begin
          x_d     = emit_ok ? emit_pos : '0;
          state_d = S_DCHK;
        end else if (!emit_ok || job_ready_i) begin
          pos_d   = pos_q + 1'b1;
          wp_d    = (wp_q == AW'(D-1)) ? '0 : wp_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DCHK: begin
        state_d = (XW'(x_q) > XW'(lo_q) + XW'(r_q)) ? S_DSUB : S_DEMIT;
      end
      S_DSUB: begin
        for (int c = 0; c < 4; c++) begin
          sum_d[c] = sum_q[c] - SW'(rd_q[8*c +: 8]);
        end
        cnt_d   = cnt_q - CW'(1);
        tail_d  = (tail_q == AW'(D-1)) ? '0 : tail_q + 1'b1;
        lo_d    = lo_q + 1'b1;
        state_d = S_DEMIT;
      end
      S_DEMIT: begin
        if (job_ready_i) begin
          if (x_q == pos_q) begin
            // line done: start the next one clean
            sum_d   = '0;
            cnt_d   = '0;
            pos_d   = '0;
            wp_d    = '0;
            tail_d  = '0;
            lo_d    = '0;
            state_d = S_IDLE;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = S_DCHK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      lo_q    <= '0;
      x_q     <= '0;
      r_q     <= '0;
      last_q  <= 1'b0;
      drop_q  <= 1'b0;
      wp_q    <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      lo_q    <= lo_d;
      x_q     <= x_d;
      r_q     <= r_d;
      last_q  <= last_d;
      drop_q  <= drop_d;
      wp_q    <= wp_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

endmodule

// File: hw/rtl/bblp_back.sv
// ----------------------------------------------------------------------------
// bblp_back: divider back end
// Restoring division of four channel sums by the window count, one quotient
// bit per cycle into a one-entry result register; the last bit waits while it is full.
// ----------------------------------------------------------------------------
module bblp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  bblp_pkg::job_t    job_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bblp_pkg::result_t res_o
);

  localparam int unsigned SW = bblp_pkg::SumW;
  localparam int unsigned TW = SW + 1;

  logic                          busy_q;
  logic [2:0]                    step_q;
  logic [3:0][SW-1:0]            rem_q;
  logic [3:0][7:0]               quo_q;
  logic [bblp_pkg::CntW-1:0]     cnt_q;
  logic [bblp_pkg::PosW-1:0]     pos_q;
  logic                          last_q;
  logic                          out_valid_q;
  bblp_pkg::result_t             res_q;
  logic                          out_free, advance;
  logic [TW-1:0]                 divisor;
  logic [3:0]                    qbit;
  logic [3:0][SW-1:0]            rem_next;
  logic [3:0][7:0]               quo_next;

  assign job_ready_o = !busy_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign out_free    = !out_valid_q || res_ready_i;
  assign advance     = busy_q && ((step_q != 3'd0) || out_free);
  assign divisor     = TW'(cnt_q) << step_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qbit[c]     = TW'(rem_q[c]) >= divisor;
      rem_next[c] = qbit[c] ? SW'(TW'(rem_q[c]) - divisor) : rem_q[c];
      quo_next[c] = {quo_q[c][6:0], qbit[c]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && job_valid_i) begin
      rem_q  <= job_i.sums;
      quo_q  <= '0;
      cnt_q  <= job_i.count;
      pos_q  <= job_i.pos;
      last_q <= job_i.last;
    end else if (advance) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (advance && step_q == 3'd0) begin
      res_q.blur_blue    <= quo_next[0];
      res_q.blur_green   <= quo_next[1];
      res_q.blur_red     <= quo_next[2];
      res_q.blur_alpha   <= quo_next[3];
      res_q.out_position <= pos_q;
      res_q.out_line_end <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_q && job_valid_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd7;
      end else if (advance) begin
        step_q <= step_q - 1'b1;
        if (step_q == 3'd0) begin
          busy_q <= 1'b0;
        end
      end
      if (advance && step_q == 3'd0) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/box_blur_line_pass.sv
// ----------------------------------------------------------------------------
// box_blur_line_pass: one line pass of a clipped-edge box blur
// Running-sum window front end, job queue, serial divider back end.
// ----------------------------------------------------------------------------
// Flow: an accepted pixel passes the front's add and emit states, where its
// job is offered to the queue; the divider then loads the job and registers
// its result beat once the last quotient bit is done.
// The bit-serial divider takes no new job until the current one is done and
// sets the throughput. The front takes one pixel at a time; at line end it
// drains each result through check and emit states, plus subtract on a drop.
// Reset: async active low; sums, positions and pointers clear, radius goes
// to 4. The window store has no reset and is only read where written.
module box_blur_line_pass #(
  parameter int unsigned MAX_RADIUS = bblp_pkg::MaxRadiusDef,
  parameter int unsigned MAX_LINE   = bblp_pkg::MaxLineDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel queue side
  input  logic              push,
  output logic              full,
  input  bblp_pkg::pixel_t  pixel_i,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output bblp_pkg::result_t result_o,
  // radius register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [5:0]        cfg_data_i
);

  logic [5:0]     radius_q;
  logic           pix_ready;
  logic           fj_valid, fj_ready;
  bblp_pkg::job_t fj;
  logic           bj_valid, bj_ready;
  bblp_pkg::job_t bj;
  logic           res_valid;

  // the radius is latched by the front at each line's first pixel, so a
  // write mid line only affects the next line
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 6'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  assign full  = !pix_ready;
  assign empty = !res_valid;

  // front: window store, running sums, line-end drain
  bblp_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (push),
    .pix_ready_o (pix_ready),
    .pix_i       (pixel_i),
    .radius_i    (radius_q),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj)
  );

  // decouples the front from divider stalls
  bblp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fj_valid),
    .in_ready_o  (fj_ready),
    .in_i        (fj),
    .out_valid_o (bj_valid),
    .out_ready_i (bj_ready),
    .out_o       (bj)
  );

  // back: per-channel sum / count, result beat held until popped
  bblp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj),
    .res_valid_o (res_valid),
    .res_ready_i (pop),
    .res_o       (result_o)
  );

endmodule
